/* rtl/itpc_pkg.sv */
package itpc_pkg;

    localparam int ItemW    = 16;
    localparam int UtilW    = 32;
    localparam int TwuW     = 48;
    localparam int PeriodW  = 17;
    localparam int CfgDataW = 48;
    localparam int CfgIdxW  = 2;

    localparam int NumItemsDef = 16;
    localparam int MaxTransDef = 65536;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ITEMSET_MASK      = 2'd0,
        CFG_UTILITY_THRESHOLD = 2'd1,
        CFG_TWU_THRESHOLD     = 2'd2,
        CFG_PERIOD_LIMIT      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [ItemW-1:0] item_mask;
        logic [UtilW-1:0] trans_utility;
        logic             last_trans;
    } t_req;

    typedef struct packed {
        logic [TwuW-1:0]    twu_sum;
        logic [PeriodW-1:0] max_period;
        logic               twu_pass;
        logic               period_pass;
    } t_rsp;

    typedef struct packed {
        logic [ItemW-1:0]   itemset_mask;
        logic [UtilW-1:0]   utility_threshold;
        logic [TwuW-1:0]    twu_threshold;
        logic [PeriodW-1:0] period_limit;
    } t_cfg;

endpackage

/* rtl/itpc_core.sv */
module itpc_core #(
    parameter int NUM_ITEMS = itpc_pkg::NumItemsDef,
    parameter int MAX_TRANS = itpc_pkg::MaxTransDef
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  itpc_pkg::t_req i_req,
    input  itpc_pkg::t_cfg i_cfg,
    output itpc_pkg::t_rsp o_rsp
);

    localparam int ItemW   = itpc_pkg::ItemW;
    localparam int UtilW   = itpc_pkg::UtilW;
    localparam int TwuW    = itpc_pkg::TwuW;
    localparam int PeriodW = itpc_pkg::PeriodW;
    localparam int PosW    = $clog2(MAX_TRANS + 2);
    localparam int CmpW    = (PosW > PeriodW) ? PosW : PeriodW;

    localparam logic [ItemW-1:0] ItemBits = (NUM_ITEMS >= ItemW) ? {ItemW{1'b1}}
                                          : ItemW'((64'd1 << NUM_ITEMS) - 64'd1);
    localparam logic [PosW-1:0]  MaxPos   = PosW'(MAX_TRANS);

    logic [PosW-1:0] r_cnt, n_cnt;
    logic [TwuW-1:0] r_twu, n_twu;
    logic [PosW-1:0] r_last_pos, n_last_pos;
    logic [PosW-1:0] r_gap_max, n_gap_max;
    logic            r_any, n_any;

    logic [ItemW-1:0] items;
    logic [ItemW-1:0] need;
    logic             contain;
    logic             keep;
    logic [TwuW:0]    twu_sum;
    logic [PosW-1:0]  gap;
    logic [PosW-1:0]  tail;
    logic [PosW-1:0]  period;
    logic [CmpW-1:0]  period_ext;

    always_comb begin
        items   = i_req.item_mask & ItemBits;
        need    = i_cfg.itemset_mask & ItemBits;
        contain = ((items & need) == need);
        keep    = contain && (i_req.trans_utility >= i_cfg.utility_threshold);

        n_cnt = (r_cnt < MaxPos) ? r_cnt + PosW'(1) : r_cnt;

        twu_sum = {1'b0, r_twu} + (TwuW+1)'(i_req.trans_utility);
        n_twu   = r_twu;
        if (contain) begin
            n_twu = twu_sum[TwuW] ? {TwuW{1'b1}} : twu_sum[TwuW-1:0];
        end

        gap        = n_cnt - r_last_pos;
        n_gap_max  = r_gap_max;
        n_last_pos = r_last_pos;
        n_any      = r_any;
        if (keep) begin
            if (gap > r_gap_max) begin
                n_gap_max = gap;
            end
            n_last_pos = n_cnt;
            n_any      = 1'b1;
        end

        tail   = n_cnt + PosW'(1) - n_last_pos;
        period = '0;
        if (n_any) begin
            period = (tail > n_gap_max) ? tail : n_gap_max;
        end
        period_ext = CmpW'(period);

        o_rsp.twu_sum     = n_twu;
        o_rsp.max_period  = period_ext[PeriodW-1:0];
        o_rsp.twu_pass    = (n_twu >= i_cfg.twu_threshold);
        o_rsp.period_pass = n_any && (period_ext <= CmpW'(i_cfg.period_limit));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_twu      <= '0;
            r_last_pos <= '0;
            r_gap_max  <= '0;
            r_any      <= 1'b0;
        end else if (i_accept) begin
            if (i_req.last_trans) begin
                r_cnt      <= '0;
                r_twu      <= '0;
                r_last_pos <= '0;
                r_gap_max  <= '0;
                r_any      <= 1'b0;
            end else begin
                r_cnt      <= n_cnt;
                r_twu      <= n_twu;
                r_last_pos <= n_last_pos;
                r_gap_max  <= n_gap_max;
                r_any      <= n_any;
            end
        end
    end

endmodule

/* rtl/itemset_twu_period_checker.sv */
// Streams one transaction per request and, on the request marked last_trans, delivers
// one result: the transaction-weighted utility of the configured itemset (saturating
// at 48 bits), the largest period between kept transactions including the head and
// tail gaps, and the two pass flags; the running state then clears for the next
// database. A request is taken every cycle unless stalled: the itemset test, the
// 48-bit utility add and the gap update sit in one combinational step ahead of the
// result register. Non-last requests are taken even while a result waits; a last
// request waits only while the held result is stalled. The user writes configuration
// through the index port only while no database is in flight, unchecked by the block.
module itemset_twu_period_checker #(
    parameter int NUM_ITEMS = itpc_pkg::NumItemsDef,
    parameter int MAX_TRANS = itpc_pkg::MaxTransDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  itpc_pkg::t_req                i_req,
    output logic                          o_valid,
    input  logic                          i_stall,
    output itpc_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_we,
    input  logic [itpc_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [itpc_pkg::CfgDataW-1:0] i_cfg_data
);

    itpc_pkg::t_cfg r_cfg;
    itpc_pkg::t_rsp r_rsp;
    itpc_pkg::t_rsp rsp;
    logic           r_out_valid;
    logic           accept;

    assign o_stall = r_out_valid && i_stall && i_req.last_trans;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (itpc_pkg::t_cfg_idx'(i_cfg_index))
                itpc_pkg::CFG_ITEMSET_MASK: begin
                    r_cfg.itemset_mask <= i_cfg_data[itpc_pkg::ItemW-1:0];
                end
                itpc_pkg::CFG_UTILITY_THRESHOLD: begin
                    r_cfg.utility_threshold <= i_cfg_data[itpc_pkg::UtilW-1:0];
                end
                itpc_pkg::CFG_TWU_THRESHOLD: begin
                    r_cfg.twu_threshold <= i_cfg_data[itpc_pkg::TwuW-1:0];
                end
                itpc_pkg::CFG_PERIOD_LIMIT: begin
                    r_cfg.period_limit <= i_cfg_data[itpc_pkg::PeriodW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    itpc_core #(
        .NUM_ITEMS (NUM_ITEMS),
        .MAX_TRANS (MAX_TRANS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .i_cfg    (r_cfg),
        .o_rsp    (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && i_req.last_trans) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.last_trans) begin
            r_rsp <= rsp;
        end
    end

endmodule

/* verif/itemset_twu_period_checker_test.sv */
module itemset_twu_period_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1_000_000;
    localparam int LongDbLen  = 30;
    localparam int RandomReqs = 950;

    class itemset_tally;
        itpc_pkg::t_cfg               cfg;
        logic [itpc_pkg::PeriodW-1:0] position;
        logic [itpc_pkg::TwuW-1:0]    twu_acc;
        logic [itpc_pkg::PeriodW-1:0] last_kept;
        logic [itpc_pkg::PeriodW-1:0] gap_max;
        bit                           any_kept;
        itpc_pkg::t_rsp               due_verdicts[$];
        int                           mismatches;

        function new();
            cfg        = '0;
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            position  = '0;
            twu_acc   = '0;
            last_kept = '0;
            gap_max   = '0;
            any_kept  = 1'b0;
        endfunction

        function void add_transaction(itpc_pkg::t_req r);
            logic [itpc_pkg::TwuW:0]      sum;
            logic [itpc_pkg::PeriodW-1:0] gap;
            logic [itpc_pkg::PeriodW-1:0] tail;
            logic [itpc_pkg::PeriodW-1:0] period;
            itpc_pkg::t_rsp               v;
            if (position < itpc_pkg::PeriodW'(itpc_pkg::MaxTransDef)) begin
                position = position + 1'b1;
            end
            if ((r.item_mask & cfg.itemset_mask) == cfg.itemset_mask) begin
                sum = {1'b0, twu_acc} + (itpc_pkg::TwuW+1)'(r.trans_utility);
                twu_acc = sum[itpc_pkg::TwuW] ? '1 : sum[itpc_pkg::TwuW-1:0];
                if (r.trans_utility >= cfg.utility_threshold) begin
                    gap = position - last_kept;
                    if (gap > gap_max) begin
                        gap_max = gap;
                    end
                    last_kept = position;
                    any_kept  = 1'b1;
                end
            end
            if (!r.last_trans) begin
                return;
            end
            period        = '0;
            v.period_pass = 1'b0;
            if (any_kept) begin
                tail          = position + 1'b1 - last_kept;
                period        = (gap_max > tail) ? gap_max : tail;
                v.period_pass = (period <= cfg.period_limit);
            end
            v.twu_sum    = twu_acc;
            v.max_period = period;
            v.twu_pass   = (twu_acc >= cfg.twu_threshold);
            due_verdicts = {due_verdicts, v};
            restart();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 50) begin
                $display("%0t mismatch: %s", $time, msg);
            end
        endtask

        task check_result(itpc_pkg::t_rsp got);
            itpc_pkg::t_rsp want;
            if (due_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result, twu_sum %0h", got.twu_sum));
                return;
            end
            want = due_verdicts.pop_front();
            if (got.twu_sum !== want.twu_sum) begin
                report_mismatch($sformatf("twu_sum %0h, want %0h", got.twu_sum, want.twu_sum));
            end
            if (got.max_period !== want.max_period) begin
                report_mismatch($sformatf("max_period %0d, want %0d",
                                          got.max_period, want.max_period));
            end
            if (got.twu_pass !== want.twu_pass) begin
                report_mismatch($sformatf("twu_pass %0b, want %0b", got.twu_pass, want.twu_pass));
            end
            if (got.period_pass !== want.period_pass) begin
                report_mismatch($sformatf("period_pass %0b, want %0b",
                                          got.period_pass, want.period_pass));
            end
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    itpc_pkg::t_req                i_req;
    logic                          o_valid;
    logic                          i_stall;
    itpc_pkg::t_rsp                o_rsp;
    logic                          i_cfg_we;
    logic [itpc_pkg::CfgIdxW-1:0]  i_cfg_index;
    logic [itpc_pkg::CfgDataW-1:0] i_cfg_data;

    bit           quiet = 1'b0;
    int           cycles = 0;
    itemset_tally tally = new();

    itemset_twu_period_checker u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                tally.check_result(o_rsp);
            end
            if (i_valid && !o_stall) begin
                tally.add_transaction(i_req);
            end
        end
    end

    function automatic int idle_len();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    initial begin
        i_stall <= 1'b0;
        forever begin
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            if (!quiet && $urandom_range(0, 1) == 0) begin
                i_stall <= 1'b1;
                repeat (idle_len()) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    function automatic itpc_pkg::t_req txn(logic [itpc_pkg::ItemW-1:0] m,
                                           logic [itpc_pkg::UtilW-1:0] u, logic last);
        itpc_pkg::t_req r;
        r.item_mask     = m;
        r.trans_utility = u;
        r.last_trans    = last;
        return r;
    endfunction

    function automatic itpc_pkg::t_req random_txn(logic last);
        itpc_pkg::t_req r;
        case ($urandom_range(0, 3))
            0: r.item_mask = 16'($urandom);
            1: r.item_mask = 16'($urandom) & 16'($urandom);
            default: r.item_mask = tally.cfg.itemset_mask | 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0: r.trans_utility = '0;
            1: r.trans_utility = '1;
            2: r.trans_utility = tally.cfg.utility_threshold;
            3: r.trans_utility = tally.cfg.utility_threshold - 1'b1;
            4: r.trans_utility = tally.cfg.utility_threshold + 1'b1;
            5: r.trans_utility = $urandom_range(0, 1000);
            default: r.trans_utility = $urandom;
        endcase
        r.last_trans = last;
        return r;
    endfunction

    function automatic itpc_pkg::t_cfg random_config();
        itpc_pkg::t_cfg c;
        case ($urandom_range(0, 4))
            0: c.itemset_mask = '0;
            1: c.itemset_mask = '1;
            2: c.itemset_mask = 16'(1) << $urandom_range(0, itpc_pkg::ItemW - 1);
            default: c.itemset_mask = 16'($urandom) & 16'($urandom) & 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: c.utility_threshold = '0;
            1: c.utility_threshold = '1;
            2: c.utility_threshold = $urandom_range(0, 2000);
            default: c.utility_threshold = $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: c.twu_threshold = '0;
            1: c.twu_threshold = '1;
            2: c.twu_threshold = {16'($urandom), 32'($urandom)};
            default: c.twu_threshold = 48'($urandom) << $urandom_range(0, 5);
        endcase
        case ($urandom_range(0, 4))
            0: c.period_limit = '0;
            1: c.period_limit = itpc_pkg::PeriodW'(itpc_pkg::MaxTransDef);
            2: c.period_limit = itpc_pkg::PeriodW'($urandom_range(0, itpc_pkg::MaxTransDef));
            default: c.period_limit = itpc_pkg::PeriodW'($urandom_range(1, 40));
        endcase
        return c;
    endfunction

    task automatic put_reg(itpc_pkg::t_cfg_idx idx, logic [itpc_pkg::CfgDataW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic write_config(itpc_pkg::t_cfg c);
        put_reg(itpc_pkg::CFG_ITEMSET_MASK, itpc_pkg::CfgDataW'(c.itemset_mask));
        put_reg(itpc_pkg::CFG_UTILITY_THRESHOLD, itpc_pkg::CfgDataW'(c.utility_threshold));
        put_reg(itpc_pkg::CFG_TWU_THRESHOLD, itpc_pkg::CfgDataW'(c.twu_threshold));
        put_reg(itpc_pkg::CFG_PERIOD_LIMIT, itpc_pkg::CfgDataW'(c.period_limit));
        i_cfg_we  <= 1'b0;
        tally.cfg = c;
    endtask

    task automatic send(itpc_pkg::t_req r);
        int g;
        g = (quiet || $urandom_range(0, 2) != 0) ? 0 : idle_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
    endtask

    // hold off until every result is back, then let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tally.due_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        itpc_pkg::t_cfg c;
        int             n_rand;
        int             len;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= itpc_pkg::CFG_ITEMSET_MASK;
        i_cfg_data  <= '0;
        n_rand = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty itemset, zero thresholds: every request counts and is kept
        c = '0;
        write_config(c);
        send(txn(16'h0000, 32'h0000_0000, 1'b0));
        send(txn(16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        send(txn(16'hFFFF, 32'h0000_0000, 1'b1));
        drain();

        c.itemset_mask      = '1;
        c.utility_threshold = '1;
        c.twu_threshold     = '1;
        c.period_limit      = itpc_pkg::PeriodW'(itpc_pkg::MaxTransDef);
        write_config(c);
        // nothing kept
        send(txn(16'hFFFE, 32'hFFFF_FFFF, 1'b0));
        send(txn(16'hFFFF, 32'hFFFF_FFFE, 1'b0));
        send(txn(16'h7FFF, 32'hFFFF_FFFF, 1'b1));
        // long run back to back, kept only at the end
        quiet = 1'b1;
        for (int k = 1; k < LongDbLen; k++) begin
            send(txn(16'hFFFF, 32'hFFFF_FFFE, 1'b0));
        end
        send(txn(16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        quiet = 1'b0;
        drain();

        c.itemset_mask      = 16'h0021;
        c.utility_threshold = 32'd1000;
        c.twu_threshold     = 48'd5000;
        c.period_limit      = 17'd3;
        write_config(c);
        send(txn(16'h0021, 32'd1000, 1'b0));
        send(txn(16'h0000, 32'd5000, 1'b0));
        send(txn(16'hFFFF, 32'd999, 1'b0));
        send(txn(16'h0023, 32'd2000, 1'b0));
        send(txn(16'h0001, 32'd3000, 1'b0));
        send(txn(16'h0021, 32'd1000, 1'b1));
        drain();

        while (n_rand < RandomReqs) begin
            write_config(random_config());
            quiet = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(2, 8)) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
                for (int k = 1; k <= len; k++) begin
                    send(random_txn(k == len));
                end
                n_rand += len;
                if ($urandom_range(0, 5) == 0) begin
                    drain();
                end
            end
            drain();
        end
        repeat (8) @(posedge i_clk);

        if (tally.due_verdicts.size() != 0) begin
            tally.report_mismatch($sformatf("%0d results missing", tally.due_verdicts.size()));
        end

        if (tally.mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/itpc_pkg.sv
rtl/itpc_core.sv
rtl/itemset_twu_period_checker.sv
verif/itemset_twu_period_checker_test.sv
